@@ src/rgbc_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and pipeline stage types for the RGBC to LED drive block.
// No dependencies.
package rgbc_pkg;

  localparam int REF_COUNT  = 3;
  localparam int IDX_W      = 2;
  localparam int RAW_W      = 16;
  localparam int NORM_W     = 8;
  localparam int LEVEL_W    = 17;
  localparam int TREF_W     = 20;   // 10 * reference
  localparam int NUM_W      = 27;   // 8*norm*lit + 5*ref
  localparam int NORM_STEPS = 8;    // one quotient bit per stage
  localparam int DRV_STEPS  = 8;

  localparam logic [RAW_W-1:0]   REF_RESET  = 16'd1200;
  localparam logic [RAW_W-1:0]   REF_MIN    = 16'd10;
  localparam logic [RAW_W-1:0]   DARK_LIMIT = 16'd5;
  localparam logic [NORM_W-1:0]  NORM_MAX   = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 17'h10000;

  // captured request
  typedef struct packed {
    logic                          valid;
    logic [IDX_W-1:0]              idx;
    logic [2:0][RAW_W-1:0]         raw;
    logic [RAW_W-1:0]              clr;
    logic [RAW_W-1:0]              wref;
  } cap_t;

  // hue and level division stages
  typedef struct packed {
    logic                          valid;
    logic [IDX_W-1:0]              idx;
    logic                          dark;
    logic [RAW_W-1:0]              clr;
    logic [RAW_W-1:0]              wref;
    logic [RAW_W-1:0]              lit;
    logic                          lfull;
    logic [2:0]                    sat;
    logic [2:0][RAW_W-1:0]         rem;
    logic [2:0][NORM_W-1:0]        q;
    logic [RAW_W-1:0]              lrem;
    logic [RAW_W-1:0]              lq;
  } nstage_t;

  // drive division stages
  typedef struct packed {
    logic                          valid;
    logic [IDX_W-1:0]              idx;
    logic                          dark;
    logic [2:0][NORM_W-1:0]        nrm;
    logic [LEVEL_W-1:0]            level;
    logic [TREF_W-1:0]             tref;
    logic [2:0][TREF_W-1:0]        rem;
    logic [2:0][NORM_W-1:0]        q;
  } dstage_t;

endpackage

@@ src/rgbc_to_rgb_led_drive.sv @@
`timescale 1ns / 1ps
// RGBC reading to LED drive: top level, pipelined dividers.
// Depends on rgbc_pkg and rgbc_cfg.
//
// One request is one raw red/green/blue/clear reading tagged with a sensor
// index. The block returns the hue normalized to 0..255 against the clear
// channel (saturating), the brightness level min(clear/ref,1) in Q16, and the
// three LED duties norm*level*0.8 rounded half up. A clear count below 5
// flags the reading dark and zeroes all values. A sensor index that is not
// below NUM_SENSORS or has no reference register yields no result. The block
// takes one request per cycle while in_stall is low. The pipeline has one
// capture stage, an init stage plus 8 stages of bit-serial restoring division
// for the hue (level divides 2 bits per stage alongside), then one multiply
// stage and 8 more division stages for the drive values. A stall on the
// output while a result waits freezes the pipe; nothing is dropped or repeated.
module rgbc_to_rgb_led_drive
  import rgbc_pkg::*;
#(
  parameter int NUM_SENSORS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [RAW_W-1:0]     cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IDX_W-1:0]     in_sensor_index,
  input  logic [RAW_W-1:0]     in_raw_red,
  input  logic [RAW_W-1:0]     in_raw_green,
  input  logic [RAW_W-1:0]     in_raw_blue,
  input  logic [RAW_W-1:0]     in_raw_clear,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     out_sensor_echo,
  output logic                 out_dark,
  output logic [NORM_W-1:0]    out_norm_red,
  output logic [NORM_W-1:0]    out_norm_green,
  output logic [NORM_W-1:0]    out_norm_blue,
  output logic [LEVEL_W-1:0]   out_level_q16,
  output logic [NORM_W-1:0]    out_drive_red,
  output logic [NORM_W-1:0]    out_drive_green,
  output logic [NORM_W-1:0]    out_drive_blue
);

  logic            en;
  logic [RAW_W-1:0] sel_ref;

  cap_t    cap_r, cap_nxt;
  nstage_t n_r   [NORM_STEPS+1];
  nstage_t n_nxt [NORM_STEPS+1];
  dstage_t d_r   [DRV_STEPS+1];
  dstage_t d_nxt [DRV_STEPS+1];

  // global advance: the pipe only holds when a finished result is stalled
  assign en       = !(d_r[DRV_STEPS].valid && out_stall);
  assign in_stall = !en;

  rgbc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_idx    (in_sensor_index),
    .rd_ref    (sel_ref)
  );

  // capture; unknown sensors are dropped here
  always_comb begin
    cap_nxt.valid  = in_valid && (int'(in_sensor_index) < NUM_SENSORS)
                     && (int'(in_sensor_index) < REF_COUNT);
    cap_nxt.idx    = in_sensor_index;
    cap_nxt.raw[0] = in_raw_red;
    cap_nxt.raw[1] = in_raw_green;
    cap_nxt.raw[2] = in_raw_blue;
    cap_nxt.clr    = in_raw_clear;
    cap_nxt.wref   = sel_ref;
  end

  // hue / level division
  always_comb begin
    logic [23:0]      num;
    logic [RAW_W:0]   t;
    logic [RAW_W:0]   lt;
    // init: numerator raw*255 split into a high remainder and low quotient bits
    n_nxt[0].valid = cap_r.valid;
    n_nxt[0].idx   = cap_r.idx;
    n_nxt[0].dark  = cap_r.clr < DARK_LIMIT;
    n_nxt[0].clr   = cap_r.clr;
    n_nxt[0].wref  = cap_r.wref;
    n_nxt[0].lit   = (cap_r.clr < cap_r.wref) ? cap_r.clr : cap_r.wref;
    n_nxt[0].lfull = cap_r.clr >= cap_r.wref;
    n_nxt[0].lrem  = (cap_r.clr < cap_r.wref) ? cap_r.clr : cap_r.wref;
    n_nxt[0].lq    = '0;
    for (int j = 0; j < 3; j++) begin
      num = {cap_r.raw[j], 8'd0} - {8'd0, cap_r.raw[j]};
      n_nxt[0].sat[j] = num[23:8] >= cap_r.clr;
      n_nxt[0].rem[j] = num[23:8];
      n_nxt[0].q[j]   = num[7:0];
    end
    for (int k = 0; k < NORM_STEPS; k++) begin
      n_nxt[k+1] = n_r[k];
      for (int j = 0; j < 3; j++) begin
        t = {n_r[k].rem[j], n_r[k].q[j][NORM_W-1]};
        if (t >= {1'b0, n_r[k].clr}) begin
          n_nxt[k+1].rem[j] = RAW_W'(t - {1'b0, n_r[k].clr});
          n_nxt[k+1].q[j]   = {n_r[k].q[j][NORM_W-2:0], 1'b1};
        end else begin
          n_nxt[k+1].rem[j] = t[RAW_W-1:0];
          n_nxt[k+1].q[j]   = {n_r[k].q[j][NORM_W-2:0], 1'b0};
        end
      end
      // level: two quotient bits per stage, low numerator bits are zero
      lt = {n_r[k].lrem, 1'b0};
      if (lt >= {1'b0, n_r[k].wref}) begin
        lt = {RAW_W'(lt - {1'b0, n_r[k].wref}), 1'b0};
        n_nxt[k+1].lq[1] = 1'b1;
      end else begin
        lt = {lt[RAW_W-1:0], 1'b0};
        n_nxt[k+1].lq[1] = 1'b0;
      end
      if (lt >= {1'b0, n_r[k].wref}) begin
        n_nxt[k+1].lrem  = RAW_W'(lt - {1'b0, n_r[k].wref});
        n_nxt[k+1].lq[0] = 1'b1;
      end else begin
        n_nxt[k+1].lrem  = lt[RAW_W-1:0];
        n_nxt[k+1].lq[0] = 1'b0;
      end
      n_nxt[k+1].lq[RAW_W-1:2] = n_r[k].lq[RAW_W-3:0];
    end
  end

  // drive: multiply then division by 10*ref
  always_comb begin
    logic [23:0]       prod;
    logic [NUM_W-1:0]  num;
    logic [TREF_W:0]   t;
    logic [NORM_W-1:0] nv;
    d_nxt[0].valid = n_r[NORM_STEPS].valid;
    d_nxt[0].idx   = n_r[NORM_STEPS].idx;
    d_nxt[0].dark  = n_r[NORM_STEPS].dark;
    d_nxt[0].level = n_r[NORM_STEPS].lfull ? LEVEL_ONE : {1'b0, n_r[NORM_STEPS].lq};
    d_nxt[0].tref  = {1'b0, n_r[NORM_STEPS].wref, 3'd0}
                     + {3'd0, n_r[NORM_STEPS].wref, 1'b0};
    for (int j = 0; j < 3; j++) begin
      nv   = n_r[NORM_STEPS].sat[j] ? NORM_MAX : n_r[NORM_STEPS].q[j];
      prod = 24'(nv) * 24'(n_r[NORM_STEPS].lit);
      num  = {prod, 3'd0} + {9'd0, n_r[NORM_STEPS].wref, 2'd0}
             + {11'd0, n_r[NORM_STEPS].wref};
      d_nxt[0].nrm[j] = nv;
      d_nxt[0].rem[j] = {1'b0, num[NUM_W-1:8]};
      d_nxt[0].q[j]   = num[7:0];
    end
    for (int k = 0; k < DRV_STEPS; k++) begin
      d_nxt[k+1] = d_r[k];
      for (int j = 0; j < 3; j++) begin
        t = {d_r[k].rem[j], d_r[k].q[j][NORM_W-1]};
        if (t >= {1'b0, d_r[k].tref}) begin
          d_nxt[k+1].rem[j] = TREF_W'(t - {1'b0, d_r[k].tref});
          d_nxt[k+1].q[j]   = {d_r[k].q[j][NORM_W-2:0], 1'b1};
        end else begin
          d_nxt[k+1].rem[j] = t[TREF_W-1:0];
          d_nxt[k+1].q[j]   = {d_r[k].q[j][NORM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r.valid <= 1'b0;
      for (int k = 0; k <= NORM_STEPS; k++) n_r[k].valid <= 1'b0;
      for (int k = 0; k <= DRV_STEPS; k++)  d_r[k].valid <= 1'b0;
    end else if (en) begin
      cap_r <= cap_nxt;
      for (int k = 0; k <= NORM_STEPS; k++) n_r[k] <= n_nxt[k];
      for (int k = 0; k <= DRV_STEPS; k++)  d_r[k] <= d_nxt[k];
    end
  end

  // dark readings report zeros in every value field
  always_comb begin
    out_valid       = d_r[DRV_STEPS].valid;
    out_sensor_echo = d_r[DRV_STEPS].idx;
    out_dark        = d_r[DRV_STEPS].dark;
    if (d_r[DRV_STEPS].dark) begin
      out_norm_red    = '0;
      out_norm_green  = '0;
      out_norm_blue   = '0;
      out_level_q16   = '0;
      out_drive_red   = '0;
      out_drive_green = '0;
      out_drive_blue  = '0;
    end else begin
      out_norm_red    = d_r[DRV_STEPS].nrm[0];
      out_norm_green  = d_r[DRV_STEPS].nrm[1];
      out_norm_blue   = d_r[DRV_STEPS].nrm[2];
      out_level_q16   = d_r[DRV_STEPS].level;
      out_drive_red   = d_r[DRV_STEPS].q[0];
      out_drive_green = d_r[DRV_STEPS].q[1];
      out_drive_blue  = d_r[DRV_STEPS].q[2];
    end
  end

endmodule

@@ src/rgbc_cfg.sv @@
`timescale 1ns / 1ps
// White reference register file with write filtering and per-sensor lookup.
// Depends on rgbc_pkg.
module rgbc_cfg
  import rgbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [RAW_W-1:0] cfg_data,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [RAW_W-1:0] rd_ref
);

  logic [REF_COUNT-1:0][RAW_W-1:0] wref_r;

  // writes below the minimum or past the last register are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REF_COUNT; i++) wref_r[i] <= REF_RESET;
    end else if (cfg_we && (int'(cfg_index) < REF_COUNT) && (cfg_data >= REF_MIN)) begin
      wref_r[cfg_index[1:0]] <= cfg_data;
    end
  end

  always_comb begin
    case (rd_idx)
      2'd0:    rd_ref = wref_r[0];
      2'd1:    rd_ref = wref_r[1];
      2'd2:    rd_ref = wref_r[2];
      default: rd_ref = REF_RESET;
    endcase
  end

endmodule

@@ tb/tb_rgbc_to_rgb_led_drive.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rgbc_to_rgb_led_drive: directed table, then random readings.
// Depends on rgbc_pkg and the rgbc_to_rgb_led_drive RTL; results checked by an in-bench predictor.
module tb_rgbc_to_rgb_led_drive;
  import rgbc_pkg::*;

  // register indexes on the config port; index 3 has no register
  localparam logic [IDX_W-1:0] REG_REF0 = 2'd0;
  localparam logic [IDX_W-1:0] REG_REF1 = 2'd1;
  localparam logic [IDX_W-1:0] REG_REF2 = 2'd2;
  localparam logic [IDX_W-1:0] REG_NONE = 2'd3;
  localparam logic [IDX_W-1:0] SENSOR_NONE = 2'd3;  // unknown sensor, no result

  localparam int PIPE_LAT    = 19;
  localparam int DRAIN_WAIT  = 2 * PIPE_LAT + 4;  // covers requests that make no result
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RAND_PER_PHASE = 375;
  localparam int N_DIR = 13;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [RAW_W-1:0] r, g, b, c;
  } reading_t;

  typedef struct {
    logic [IDX_W-1:0]   echo;
    logic               dark;
    logic [NORM_W-1:0]  nr, ng, nb;
    logic [LEVEL_W-1:0] level;
    logic [NORM_W-1:0]  dr, dg, db;
  } led_result_t;

  typedef struct {
    reading_t    rd;
    bit          typed;   // expected value written in the row
    led_result_t want;
  } dir_row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [RAW_W-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [IDX_W-1:0] in_sensor_index;
  logic [RAW_W-1:0] in_raw_red, in_raw_green, in_raw_blue, in_raw_clear;
  logic out_valid, out_stall;
  logic [IDX_W-1:0] out_sensor_echo;
  logic out_dark;
  logic [NORM_W-1:0] out_norm_red, out_norm_green, out_norm_blue;
  logic [LEVEL_W-1:0] out_level_q16;
  logic [NORM_W-1:0] out_drive_red, out_drive_green, out_drive_blue;

  rgbc_to_rgb_led_drive #(.NUM_SENSORS(3)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sensor_index(in_sensor_index), .in_raw_red(in_raw_red),
    .in_raw_green(in_raw_green), .in_raw_blue(in_raw_blue), .in_raw_clear(in_raw_clear),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sensor_echo(out_sensor_echo), .out_dark(out_dark),
    .out_norm_red(out_norm_red), .out_norm_green(out_norm_green),
    .out_norm_blue(out_norm_blue), .out_level_q16(out_level_q16),
    .out_drive_red(out_drive_red), .out_drive_green(out_drive_green),
    .out_drive_blue(out_drive_blue)
  );

  // predictor's copy of the white references
  logic [RAW_W-1:0] white_ref [REF_COUNT];
  led_result_t pending_results[$];
  int errors = 0;
  int n_req = 0, n_res = 0, n_dark = 0, n_ignored = 0;
  int cycles = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------
  function automatic logic [NORM_W-1:0] hue_norm(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] c);
    logic [31:0] q;
    q = (32'(raw) * 32'd255) / 32'(c);
    return (q > 32'd255) ? NORM_MAX : q[NORM_W-1:0];
  endfunction

  // norm * level * 0.8, rounded half up, done exactly in integers
  function automatic logic [NORM_W-1:0] led_duty(logic [NORM_W-1:0] n, logic [RAW_W-1:0] lit,
                                                 logic [RAW_W-1:0] wr);
    longint unsigned num;
    longint unsigned q;
    num = 64'd8 * 64'(n) * 64'(lit) + 64'd5 * 64'(wr);
    q = num / (64'd10 * 64'(wr));
    return q[NORM_W-1:0];
  endfunction

  // returns 0 when the reading makes no result
  function automatic bit led_predict(reading_t rd, output led_result_t res);
    logic [RAW_W-1:0] wr, lit;
    longint unsigned lvl;
    res = '{default: '0};
    if (rd.idx == SENSOR_NONE) return 1'b0;
    wr = white_ref[rd.idx];
    res.echo = rd.idx;
    if (rd.c < DARK_LIMIT) begin
      res.dark = 1'b1;
      return 1'b1;
    end
    lit = (rd.c < wr) ? rd.c : wr;
    res.nr = hue_norm(rd.r, rd.c);
    res.ng = hue_norm(rd.g, rd.c);
    res.nb = hue_norm(rd.b, rd.c);
    lvl = (64'(lit) * 64'd65536) / 64'(wr);
    res.level = lvl[LEVEL_W-1:0];
    res.dr = led_duty(res.nr, lit, wr);
    res.dg = led_duty(res.ng, lit, wr);
    res.db = led_duty(res.nb, lit, wr);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------
  // Result checking, sampled at the rising edge
  // ---------------------------------------------------------------
  task automatic cmp_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    led_result_t w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles", $time, cycles);
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, got sensor %0d", $time,
                 out_sensor_echo);
      end else begin
        w = pending_results.pop_front();
        n_res++;
        if (w.dark) n_dark++;
        cmp_field("sensor_echo", w.echo,  out_sensor_echo);
        cmp_field("dark",        w.dark,  out_dark);
        cmp_field("norm_red",    w.nr,    out_norm_red);
        cmp_field("norm_green",  w.ng,    out_norm_green);
        cmp_field("norm_blue",   w.nb,    out_norm_blue);
        cmp_field("level_q16",   w.level, out_level_q16);
        cmp_field("drive_red",   w.dr,    out_drive_red);
        cmp_field("drive_green", w.dg,    out_drive_green);
        cmp_field("drive_blue",  w.db,    out_drive_blue);
      end
    end
  end

  // receiver back-pressure, changed at the falling edge
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------
  // Request driver. Called at a falling edge, returns at a falling edge;
  // in_valid gets one assignment per edge so back-to-back requests hold it high.
  // ---------------------------------------------------------------
  task automatic send_reading(reading_t rd, bit typed, led_result_t want);
    led_result_t p;
    bit has_res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_sensor_index <= rd.idx;
    in_raw_red      <= rd.r;
    in_raw_green    <= rd.g;
    in_raw_blue     <= rd.b;
    in_raw_clear    <= rd.c;
    do @(posedge clk); while (in_stall);
    // predict with the references in force when the request is taken
    has_res = led_predict(rd, p);
    n_req++;
    if (!has_res) n_ignored++;
    else pending_results.push_back(typed ? want : p);
    @(negedge clk);
  endtask

  // stop sending and let the pipe empty, including requests that made no result
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_ref(logic [IDX_W-1:0] idx, logic [RAW_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    // too-small values and the missing register are dropped
    if (idx != REG_NONE && val >= REF_MIN) white_ref[idx] = val;
    @(negedge clk);
  endtask

  // random reading, biased toward interesting clear counts
  function automatic reading_t rand_reading();
    reading_t rd;
    int sel;
    rd.idx = ($urandom_range(99) < 8) ? SENSOR_NONE : 2'($urandom_range(2));
    sel = $urandom_range(9);
    case (sel)
      0:       rd.c = 16'($urandom_range(9));        // around the dark limit
      1, 2:    rd.c = 16'($urandom_range(200));
      3, 4: begin                                    // near the white reference
        if (rd.idx == SENSOR_NONE) rd.c = 16'($urandom);
        else rd.c = 16'(int'(white_ref[rd.idx]) + $urandom_range(20) - 10);
      end
      default: rd.c = 16'($urandom);
    endcase
    if ($urandom_range(1)) begin
      // hue channels mostly below clear, like real readings
      rd.r = 16'($urandom_range(int'(rd.c)));
      rd.g = 16'($urandom_range(int'(rd.c)));
      rd.b = 16'($urandom_range(int'(rd.c)));
    end else begin
      rd.r = 16'($urandom);
      rd.g = 16'($urandom);
      rd.b = 16'($urandom);
    end
    return rd;
  endfunction

  // ---------------------------------------------------------------
  // Directed table: typed expectations where they are obvious at reset refs
  // ---------------------------------------------------------------
  dir_row_t dir_rows [N_DIR];

  initial begin
    led_result_t none;
    int idle_tab [4];
    int stall_tab [4];
    none = '{default: '0};
    idle_tab  = '{0, 82, 0, 27};
    stall_tab = '{0, 0, 82, 27};

    // full scale white at reference
    dir_rows[0]  = '{'{REG_REF0, 16'd1200, 16'd1200, 16'd1200, 16'd1200}, 1'b1,
                     '{2'd0, 1'b0, 8'd255, 8'd255, 8'd255, 17'h10000, 8'd204, 8'd204, 8'd204}};
    // max clear, no color
    dir_rows[1]  = '{'{REG_REF1, 16'd0, 16'd0, 16'd0, 16'hFFFF}, 1'b1,
                     '{2'd1, 1'b0, 8'd0, 8'd0, 8'd0, 17'h10000, 8'd0, 8'd0, 8'd0}};
    // dark: clear zero, clear just under the limit
    dir_rows[2]  = '{'{REG_REF2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0}, 1'b1,
                     '{2'd2, 1'b1, 8'd0, 8'd0, 8'd0, 17'd0, 8'd0, 8'd0, 8'd0}};
    dir_rows[3]  = '{'{REG_REF0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd4}, 1'b1,
                     '{2'd0, 1'b1, 8'd0, 8'd0, 8'd0, 17'd0, 8'd0, 8'd0, 8'd0}};
    dir_rows[4]  = '{'{REG_REF1, 16'd0, 16'd0, 16'd0, 16'd5}, 1'b0, none};
    dir_rows[5]  = '{'{REG_REF2, 16'd5, 16'd5, 16'd5, 16'd5}, 1'b0, none};
    // unknown sensor: no result
    dir_rows[6]  = '{'{SENSOR_NONE, 16'd100, 16'd100, 16'd100, 16'd100}, 1'b0, none};
    dir_rows[7]  = '{'{REG_REF0, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF}, 1'b0, none};
    dir_rows[8]  = '{'{REG_REF1, 16'd600, 16'd300, 16'd100, 16'd600}, 1'b0, none};
    dir_rows[9]  = '{'{REG_REF2, 16'd1, 16'd2, 16'd3, 16'd1199}, 1'b0, none};
    dir_rows[10] = '{'{REG_REF0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1201}, 1'b0, none};
    dir_rows[11] = '{'{SENSOR_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, none};
    dir_rows[12] = '{'{REG_REF1, 16'h5555, 16'hAAAA, 16'h1234, 16'h8000}, 1'b0, none};

    for (int i = 0; i < REF_COUNT; i++) white_ref[i] = REF_RESET;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_sensor_index = '0;
    in_raw_red = '0; in_raw_green = '0; in_raw_blue = '0; in_raw_clear = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_reading(dir_rows[i].rd, dir_rows[i].typed, dir_rows[i].want);
    drain_pipe();

    for (int ph = 0; ph < 4; ph++) begin
      // new white references for each phase, extremes included
      case (ph)
        0: begin
          write_ref(REG_REF0, 16'd10);
          write_ref(REG_REF1, 16'hFFFF);
          write_ref(REG_REF2, 16'd1000);
        end
        1: begin
          write_ref(REG_REF0, 16'hFFFF);
          write_ref(REG_REF1, 16'd10);
          write_ref(REG_REF2, 16'd9);      // below minimum: kept
          write_ref(REG_NONE, 16'd500);    // no such register
        end
        2: begin
          write_ref(REG_REF0, 16'd0);      // below minimum: kept
          write_ref(REG_REF1, 16'd11);
          write_ref(REG_REF2, 16'($urandom_range(65535, 10)));
        end
        default: begin
          for (int k = 0; k < REF_COUNT; k++)
            write_ref(2'(k), 16'($urandom_range(65535, 10)));
        end
      endcase
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // hold off once until every expected result has come back
        if (ph == 1 && n == RAND_PER_PHASE / 2) begin
          in_valid <= 1'b0;
          @(negedge clk);
          while (pending_results.size() != 0) @(negedge clk);
        end
        send_reading(rand_reading(), 1'b0, none);
      end
      drain_pipe();
    end
    recv_stall_pct = 0;

    $display("Sent %0d readings (%0d to unknown sensors); checked %0d results, %0d dark.",
             n_req, n_ignored, n_res, n_dark);
    $display("Covered four idle/stall mixes and white references from 10 to 65535.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never seen", errors, pending_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ rgbc_to_rgb_led_drive.f @@
src/rgbc_pkg.sv
src/rgbc_cfg.sv
src/rgbc_to_rgb_led_drive.sv
tb/tb_rgbc_to_rgb_led_drive.sv
